// ----- src/dersig_pkg.sv -----
package dersig_pkg;

    // Size of one raw component (r or s) in bytes.
    localparam int COMPONENT_BYTES = 32;

    // Counter width that can hold a full component length.
    localparam int CNT_W = $clog2(COMPONENT_BYTES + 1);

    // Command queue between the parser and the output sequencer.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

    // A length byte of one more than a component carries a leading pad byte.
    localparam logic [7:0] PAD_LEN  = 8'(COMPONENT_BYTES + 1);
    localparam logic [7:0] COMP_LEN = 8'(COMPONENT_BYTES);

    // Parser phases.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_LEN,
        PH_PAD,
        PH_DATA,
        PH_STAG
    } phase_t;

    // Commands the parser hands to the output sequencer.
    typedef enum logic [1:0] {
        OP_ZEROS,
        OP_DATA,
        OP_ERROR
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [7:0]       data;
        logic [CNT_W-1:0] count;
        logic             last;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } cmd_push_t;

endpackage

// ----- src/dersig_front.sv -----
module dersig_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             in_byte,
    input  logic                   start_req,
    input  logic                   queue_full,
    output dersig_pkg::cmd_push_t  wr
);

    dersig_pkg::phase_t              phase_reg, phase_next;
    logic [1:0]                      hdr_cnt_reg, hdr_cnt_next;
    logic [dersig_pkg::CNT_W-1:0]    left_reg, left_next;
    logic                            s_part_reg, s_part_next;
    logic                            accept;
    logic [1:0]                      hdr_inc;
    logic [dersig_pkg::CNT_W-1:0]    left_dec;
    logic [dersig_pkg::CNT_W-1:0]    zeros;
    logic [dersig_pkg::CNT_W-1:0]    len_short;

    // A transaction is taken whenever the command queue has room.
    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    assign hdr_inc   = hdr_cnt_reg + 2'd1;
    assign left_dec  = (left_reg == '0) ? left_reg : left_reg - 1'b1;
    assign len_short = in_byte[dersig_pkg::CNT_W-1:0];
    assign zeros     = dersig_pkg::CNT_W'(dersig_pkg::COMPONENT_BYTES) - len_short;

    // Next-state logic of the parser.
    always_comb
    begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        left_next    = left_reg;
        s_part_next  = s_part_reg;
        if (accept)
        begin
            if (start_req)
            begin
                phase_next   = dersig_pkg::PH_HDR;
                hdr_cnt_next = 2'd1;
                left_next    = '0;
                s_part_next  = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    dersig_pkg::PH_HDR:
                    begin
                        hdr_cnt_next = hdr_inc;
                        if (hdr_inc >= 2'd3)
                        begin
                            hdr_cnt_next = 2'd0;
                            phase_next   = dersig_pkg::PH_LEN;
                        end
                    end
                    dersig_pkg::PH_STAG:
                    begin
                        phase_next = dersig_pkg::PH_LEN;
                    end
                    dersig_pkg::PH_LEN:
                    begin
                        if (in_byte > dersig_pkg::PAD_LEN)
                        begin
                            phase_next = dersig_pkg::PH_IDLE;
                        end
                        else if (in_byte == dersig_pkg::PAD_LEN)
                        begin
                            left_next  = dersig_pkg::CNT_W'(dersig_pkg::COMPONENT_BYTES);
                            phase_next = dersig_pkg::PH_PAD;
                        end
                        else
                        begin
                            left_next = len_short;
                            if (in_byte == 8'd0)
                            begin
                                // Empty component: r moves to the s tag, s ends.
                                if (s_part_reg)
                                begin
                                    phase_next = dersig_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    s_part_next = 1'b1;
                                    phase_next  = dersig_pkg::PH_STAG;
                                end
                            end
                            else
                            begin
                                phase_next = dersig_pkg::PH_DATA;
                            end
                        end
                    end
                    dersig_pkg::PH_PAD:
                    begin
                        phase_next = dersig_pkg::PH_DATA;
                    end
                    dersig_pkg::PH_DATA:
                    begin
                        left_next = left_dec;
                        if (left_dec == '0)
                        begin
                            if (s_part_reg)
                            begin
                                phase_next = dersig_pkg::PH_IDLE;
                            end
                            else
                            begin
                                s_part_next = 1'b1;
                                phase_next  = dersig_pkg::PH_STAG;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = dersig_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Command generation for the output sequencer.
    always_comb
    begin
        wr.push      = 1'b0;
        wr.cmd.op    = dersig_pkg::OP_DATA;
        wr.cmd.data  = in_byte;
        wr.cmd.count = zeros;
        wr.cmd.last  = 1'b0;
        if (accept && !start_req)
        begin
            unique case (phase_reg)
                dersig_pkg::PH_LEN:
                begin
                    if (in_byte > dersig_pkg::PAD_LEN)
                    begin
                        wr.push     = 1'b1;
                        wr.cmd.op   = dersig_pkg::OP_ERROR;
                        wr.cmd.last = 1'b1;
                    end
                    else if (in_byte < dersig_pkg::COMP_LEN)
                    begin
                        wr.push     = 1'b1;
                        wr.cmd.op   = dersig_pkg::OP_ZEROS;
                        wr.cmd.last = s_part_reg && (in_byte == 8'd0);
                    end
                end
                dersig_pkg::PH_DATA:
                begin
                    wr.push     = 1'b1;
                    wr.cmd.op   = dersig_pkg::OP_DATA;
                    wr.cmd.last = s_part_reg && (left_dec == '0);
                end
                default:
                begin
                    wr.push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= dersig_pkg::PH_IDLE;
            hdr_cnt_reg <= 2'd0;
            left_reg    <= '0;
            s_part_reg  <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            left_reg    <= left_next;
            s_part_reg  <= s_part_next;
        end
    end

    // A command is only produced for a transaction that was accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr.push |-> (accept && !start_req))
        else $error("command pushed without an accepted data byte");

    // A data phase always has bytes still to pass through.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == dersig_pkg::PH_DATA) |-> (left_reg != '0))
        else $error("data phase entered with no bytes left");

endmodule

// ----- src/dersig_fifo.sv -----
module dersig_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dersig_pkg::cmd_push_t wr,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output dersig_pkg::cmd_t      head
);

    dersig_pkg::cmd_t                 slot_reg [dersig_pkg::FIFO_DEPTH];
    logic [dersig_pkg::PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [dersig_pkg::LVL_W-1:0]     level_reg, level_next;
    logic                             do_push, do_pop;

    assign full       = (level_reg == dersig_pkg::LVL_W'(dersig_pkg::FIFO_DEPTH));
    assign head_valid = (level_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = wr.push && !full;
    assign do_pop     = pop && head_valid;

    // Fill level tracking.
    always_comb
    begin
        level_next = level_reg;
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            level_reg <= level_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr.cmd;
        end
    end

    // The fill level never exceeds the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= dersig_pkg::LVL_W'(dersig_pkg::FIFO_DEPTH))
        else $error("command queue overflow");

    // The parser never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr.push)
        else $error("push into full command queue");

endmodule

// ----- src/dersig_back.sv -----
module dersig_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  dersig_pkg::cmd_t head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             last,
    output logic             bad_length
);

    logic [dersig_pkg::CNT_W-1:0] run_reg, run_next;
    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   byte_reg, byte_next;
    logic                         last_reg, last_next;
    logic                         bad_reg, bad_next;
    logic                         load;
    logic                         run_final;

    // The output register takes a new byte when it is empty or being drained.
    assign load      = head_valid && (!out_valid_reg || !out_stall);
    assign run_final = (dersig_pkg::CNT_W'(run_reg + 1'b1) == head.count);

    // Expand the head command into output bytes.
    always_comb
    begin
        run_next  = run_reg;
        pop       = 1'b0;
        byte_next = byte_reg;
        last_next = last_reg;
        bad_next  = bad_reg;
        if (load)
        begin
            unique case (head.op)
                dersig_pkg::OP_ZEROS:
                begin
                    byte_next = 8'd0;
                    last_next = head.last && run_final;
                    bad_next  = 1'b0;
                    pop       = run_final;
                    run_next  = run_final ? '0 : dersig_pkg::CNT_W'(run_reg + 1'b1);
                end
                dersig_pkg::OP_DATA:
                begin
                    byte_next = head.data;
                    last_next = head.last;
                    bad_next  = 1'b0;
                    pop       = 1'b1;
                end
                default:
                begin
                    byte_next = 8'd0;
                    last_next = 1'b1;
                    bad_next  = 1'b1;
                    pop       = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        bad_reg  <= bad_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = byte_reg;
    assign last       = last_reg;
    assign bad_length = bad_reg;

    // An error transaction is always a terminating zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_length) |-> (last && (out_byte == 8'd0)))
        else $error("error result without last or with nonzero byte");

    // The zero-run counter is only busy while a zero run is at the queue head.
    assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg != '0) |-> (head_valid && (head.op == dersig_pkg::OP_ZEROS)))
        else $error("zero-run counter active without a zero run");

endmodule

// ----- src/der_ecdsa_signature_to_raw_core.sv -----
// Converts a DER-encoded ECDSA signature, fed one byte per transaction, into the raw
// r||s form of 2*COMPONENT_BYTES bytes (64 for P-256), big-endian and zero padded,
// with last on the final s byte. start_req on a byte restarts the parser; the header
// and integer tags are skipped unchecked and short-form lengths are assumed. A length
// above COMPONENT_BYTES+1 yields a single zero byte with last and bad_length set, and
// the block then ignores bytes until the next start. Input bytes are taken at one per
// cycle, unless stalled, into a four-entry command queue, and a byte's first result
// passes through the queue and then the output register before reaching out_valid.
// The output side emits one byte per cycle unless the receiver stalls, so the input
// stalls only when four commands wait: while the receiver stalls, or while a zero-pad
// run of up to COMPONENT_BYTES bytes drains through the single output register.
module der_ecdsa_signature_to_raw_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       start_req,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last,
    output logic       bad_length
);

    dersig_pkg::cmd_push_t wr;
    dersig_pkg::cmd_t      head;
    logic                  queue_full;
    logic                  head_valid;
    logic                  pop;

    // Parser: classifies input bytes and issues commands.
    dersig_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .start_req  (start_req),
        .queue_full (queue_full),
        .wr         (wr)
    );

    // Command queue between parser and sequencer.
    dersig_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Output sequencer: expands commands into result bytes.
    dersig_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .last       (last),
        .bad_length (bad_length)
    );

endmodule
